### design/skt_pkg.sv
// shared types, sizes and key compare for the sorted key table
// no dependencies; imported by every module of the block except skt_ram
package skt_pkg;

    localparam int DEPTH        = 256;
    localparam int KEY_W        = 32;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);

    localparam int KEY_FIELD_W  = 32;
    localparam int STATUS_W     = 2;
    localparam int POSITION_W   = 8;
    localparam int TOTAL_W      = 9;
    localparam int IN_DATA_W    = ((KEY_FIELD_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STATUS_W + POSITION_W + KEY_FIELD_W + TOTAL_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int POSITION_LSB = STATUS_W;
    localparam int FKEY_LSB     = POSITION_LSB + POSITION_W;
    localparam int TOTAL_LSB    = FKEY_LSB + KEY_FIELD_W;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK   = 2'd0,
        STS_MISS = 2'd1,
        STS_FULL = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_FIRST,
        ST_LAST,
        ST_PROBE,
        ST_CMP,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_PLACE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_first;
        logic rd_last;
        logic top;
        logic probe;
        logic step;
        logic scan_rd;
        logic scan_step;
        logic miss;
        logic full;
        logic place;
        logic shift_rd;
        logic shift_wr;
        logic ins_wr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_search;
        logic is_full;
        logic range_empty;
        logic hit;
        logic gt;
        logic shift_more;
        logic out_free;
    } sts_t;

    // a greater than b, two's complement when sgn is set
    function automatic logic key_gt(input logic [KEY_W-1:0] a,
                                    input logic [KEY_W-1:0] b,
                                    input logic sgn);
        logic [KEY_W-1:0] ax;
        logic [KEY_W-1:0] bx;
        ax = a;
        bx = b;
        ax[KEY_W-1] = a[KEY_W-1] ^ sgn;
        bx[KEY_W-1] = b[KEY_W-1] ^ sgn;
        return ax > bx;
    endfunction

endpackage

### design/skt_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module skt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### design/skt_dp.sv
// datapath of the sorted key table: key store, search bounds, shift pointer,
// count, mode register and output register; uses skt_pkg and skt_ram
module skt_dp import skt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic                  signed_reg, signed_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  m_valid_reg, m_valid_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    opcode_t               op_reg, op_next;
    logic [CNT_W-1:0]      lo_reg, lo_next;
    logic [CNT_W-1:0]      hi_reg, hi_next;
    logic [IDX_W-1:0]      mid_reg, mid_next;
    logic                  eq_reg, eq_next;
    logic [CNT_W-1:0]      m_reg, m_next;
    status_t               status_reg, status_next;
    logic [IDX_W-1:0]      pos_reg, pos_next;
    logic [KEY_W-1:0]      fkey_reg, fkey_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic [CNT_W:0]        span_sum;
    logic [IDX_W-1:0]      mid_calc;
    logic                  k_gt, k_eq;
    logic                  ram_wr_en;
    logic [IDX_W-1:0]      ram_wr_addr, ram_rd_addr;
    logic [KEY_W-1:0]      ram_wr_data, ram_rd_data;

    assign span_sum = {1'b0, lo_reg} + {1'b0, hi_reg} - (CNT_W + 1)'(1);
    assign mid_calc = span_sum[IDX_W:1];
    assign k_gt     = key_gt(key_reg, ram_rd_data, signed_reg);
    assign k_eq     = (key_reg == ram_rd_data);

    assign ram_rd_addr = cmd.shift_rd ? IDX_W'(m_reg - CNT_W'(1)) :
                         cmd.rd_first ? '0 :
                         cmd.rd_last  ? IDX_W'(count_reg - CNT_W'(1)) :
                         cmd.scan_rd  ? lo_reg[IDX_W-1:0] : mid_calc;
    assign ram_wr_en   = cmd.shift_wr | cmd.ins_wr;
    assign ram_wr_addr = cmd.shift_wr ? m_reg[IDX_W-1:0] : pos_reg;
    assign ram_wr_data = cmd.shift_wr ? ram_rd_data : key_reg;

    skt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        sts.is_search   = (op_reg == OP_SEARCH);
        sts.is_full     = (count_reg == CNT_W'(DEPTH));
        sts.range_empty = !(lo_reg < hi_reg);
        sts.hit         = k_eq;
        sts.gt          = k_gt;
        sts.shift_more  = (m_reg > CNT_W'(pos_reg));
        sts.out_free    = !m_valid_reg || m_tready;
    end

    always_comb begin
        signed_next = cfg_wr_en ? cfg_wr_data : signed_reg;
        count_next  = cmd.ins_wr ? count_reg + CNT_W'(1) : count_reg;
        key_next    = key_reg;
        op_next     = op_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        eq_next     = eq_reg;
        m_next      = m_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        fkey_next   = fkey_reg;
        m_data_next = m_data_reg;
        m_valid_next = cmd.out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

        if (cmd.load) begin
            key_next    = KEY_W'(s_tdata[KEY_FIELD_W-1:0]);
            op_next     = opcode_t'(s_tuser);
            lo_next     = '0;
            hi_next     = count_reg;
            eq_next     = 1'b0;
            status_next = STS_OK;
            pos_next    = '0;
            fkey_next   = '0;
        end
        if (cmd.top) begin
            lo_next = count_reg;
        end
        if (cmd.probe) begin
            mid_next = mid_calc;
        end
        if (cmd.step) begin
            if (k_eq) begin
                if (op_reg == OP_SEARCH) begin
                    pos_next  = mid_reg;
                    fkey_next = ram_rd_data;
                end else begin
                    // equal key: walk up the run of equal entries, bounded by the count
                    lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                    hi_next = count_reg;
                    eq_next = 1'b1;
                end
            end else if (k_gt) begin
                lo_next = CNT_W'(mid_reg) + CNT_W'(1);
            end else begin
                hi_next = CNT_W'(mid_reg);
            end
        end
        if (cmd.scan_step) begin
            lo_next = lo_reg + CNT_W'(1);
        end
        if (cmd.miss) begin
            status_next = STS_MISS;
        end
        if (cmd.full) begin
            status_next = STS_FULL;
        end
        if (cmd.place) begin
            pos_next = IDX_W'(lo_reg - CNT_W'(eq_reg));
            m_next   = count_reg;
        end
        if (cmd.shift_wr) begin
            m_next = m_reg - CNT_W'(1);
        end
        if (cmd.out_load) begin
            m_data_next = OUT_DATA_W'({TOTAL_W'(count_reg), KEY_FIELD_W'(fkey_reg),
                                       POSITION_W'(pos_reg), status_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signed_reg  <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            signed_reg  <= signed_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        op_reg     <= op_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        eq_reg     <= eq_next;
        m_reg      <= m_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
        fkey_reg   <= fkey_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

### design/skt_ctrl.sv
// controller of the sorted key table: sequences search probes, entry shifts
// and result hand-off; uses skt_pkg
module skt_ctrl import skt_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  sts_t sts,
    input  logic s_tvalid,
    output logic s_tready,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                priority if (!sts.is_search && sts.is_full) begin
                    cmd.full   = 1'b1;
                    state_next = ST_DONE;
                end else if (sts.is_search) begin
                    state_next = ST_PROBE;
                end else if (sts.range_empty) begin
                    state_next = ST_PLACE;
                end else begin
                    cmd.rd_first = 1'b1;
                    state_next   = ST_FIRST;
                end
            end
            ST_FIRST: begin
                // below the first entry goes to the front
                if (!sts.gt && !sts.hit) begin
                    state_next = ST_PLACE;
                end else begin
                    cmd.rd_last = 1'b1;
                    state_next  = ST_LAST;
                end
            end
            ST_LAST: begin
                // above the last entry goes to the end
                if (sts.gt) begin
                    cmd.top    = 1'b1;
                    state_next = ST_PLACE;
                end else begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                priority if (sts.range_empty && sts.is_search) begin
                    cmd.miss   = 1'b1;
                    state_next = ST_DONE;
                end else if (sts.range_empty) begin
                    state_next = ST_PLACE;
                end else begin
                    cmd.probe  = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                cmd.step = 1'b1;
                if (sts.hit) begin
                    state_next = sts.is_search ? ST_DONE : ST_SCAN_RD;
                end else begin
                    state_next = ST_PROBE;
                end
            end
            ST_SCAN_RD: begin
                if (sts.range_empty) begin
                    state_next = ST_PLACE;
                end else begin
                    cmd.scan_rd = 1'b1;
                    state_next  = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP: begin
                if (sts.hit) begin
                    cmd.scan_step = 1'b1;
                    state_next    = ST_SCAN_RD;
                end else begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE: begin
                cmd.place  = 1'b1;
                state_next = ST_SHIFT_RD;
            end
            ST_SHIFT_RD: begin
                if (sts.shift_more) begin
                    cmd.shift_rd = 1'b1;
                    state_next   = ST_SHIFT_WR;
                end else begin
                    state_next = ST_WRITE;
                end
            end
            ST_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                state_next   = ST_SHIFT_RD;
            end
            ST_WRITE: begin
                cmd.ins_wr = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### design/sorted_key_table_core.sv
// sorted key table: up to 256 keys held in ascending order in one ram.
// s_ channel takes items: tuser is the opcode (0 insert, 1 search),
// tdata the 32-bit key. m_ channel returns one result item per input item.
// signed_keys is written through cfg_wr_en / cfg_wr_data; the user must do
// so only while idle, as the block itself does not enforce it.
// a search is a binary search over the ram of at most 9 probes, each an
// address step, then a compare on the registered read data.
// an insert first compares against the first and last entries, then searches
// and steps over a run of equal keys, then moves up one slot every larger
// entry and the last key of any equal run, whose slot the new key takes.
// a full table rejects an insert before any compare.
// one item is worked on at a time; s_tready is high only between items,
// so a new item can be taken in the cycle after the previous result is loaded.
// a stalled m_ side holds the result in the output register; the next
// item is still taken, and when it finishes it waits for the register.
// reset empties the table and selects unsigned compare; the ram itself
// is not cleared, as only slots below the count are ever read.
// uses skt_pkg, skt_ctrl, skt_dp, skt_ram
module sorted_key_table_core import skt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,   // signed_keys
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,       // key
    input  logic                  s_tuser,       // opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata        // status, position, found_key, entry_total
);

    cmd_t cmd;
    sts_t sts;

    skt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sts      (sts),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    skt_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    logic [STATUS_W-1:0]   out_status;
    logic [POSITION_W-1:0] out_position;
    logic [TOTAL_W-1:0]    out_total;

    assign out_status   = m_tdata[STATUS_W-1:0];
    assign out_position = m_tdata[POSITION_LSB +: POSITION_W];
    assign out_total    = m_tdata[TOTAL_LSB +: TOTAL_W];

`ifndef ASSERT_OFF
    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while another is in work");

    a_total_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_total <= TOTAL_W'(DEPTH)))
        else $error("entry total beyond table depth");

    a_full_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_status == STS_FULL)) |->
        ((out_position == '0) && (out_total == TOTAL_W'(DEPTH))))
        else $error("rejected insert with a table that is not full");

    a_single_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.shift_wr, cmd.ins_wr}))
        else $error("two ram writes in one cycle");
`endif

endmodule

### tb/sv/sorted_key_table_core_tb.sv
// testbench for sorted_key_table_core: directed and random insert and search items,
// each result item checked against a table of keys kept alongside the block
// depends on skt_pkg and the sorted_key_table_core design
module sorted_key_table_core_tb;
    import skt_pkg::*;

    typedef struct {
        status_t                status;
        logic [POSITION_W-1:0]  position;
        logic [KEY_FIELD_W-1:0] found_key;
        logic [TOTAL_W-1:0]     entry_total;
    } table_outcome_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic                  cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    logic [KEY_W-1:0] mirror_keys [DEPTH];
    int               mirror_count = 0;
    logic             mirror_signed = 1'b0;
    table_outcome_t   outcomes_due [$];
    int               fail_count = 0;
    bit               idle_en = 1'b1;
    int               hold_request = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sorted_key_table_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // three-way compare under the current signedness
    function automatic int key_order(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
        logic [KEY_W-1:0] ax;
        logic [KEY_W-1:0] bx;
        ax = a;
        bx = b;
        ax[KEY_W-1] = a[KEY_W-1] ^ mirror_signed;
        bx[KEY_W-1] = b[KEY_W-1] ^ mirror_signed;
        if (ax < bx) return -1;
        if (ax > bx) return 1;
        return 0;
    endfunction

    function automatic int insert_place(logic [KEY_W-1:0] k);
        int lo;
        int hi;
        int mid;
        int run;
        int c;
        if (mirror_count == 0) return 0;
        if (key_order(k, mirror_keys[0]) < 0) return 0;
        if (key_order(k, mirror_keys[mirror_count-1]) > 0) return mirror_count;
        lo = 0;
        hi = mirror_count - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            c = key_order(k, mirror_keys[mid]);
            if (c == 0) begin
                // equal run: new key lands on the last equal slot
                run = mid;
                while (run < mirror_count && key_order(k, mirror_keys[run]) == 0) run++;
                return run - 1;
            end
            if (c > 0) lo = mid + 1;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic table_outcome_t table_op_outcome(opcode_t op, logic [KEY_W-1:0] k);
        table_outcome_t r;
        int p;
        int m;
        int lo;
        int hi;
        int mid;
        int c;
        r.status    = STS_OK;
        r.position  = '0;
        r.found_key = '0;
        if (op == OP_INSERT) begin
            if (mirror_count >= DEPTH) begin
                r.status = STS_FULL;
            end else begin
                p = insert_place(k);
                for (m = mirror_count; m > p; m--) mirror_keys[m] = mirror_keys[m-1];
                mirror_keys[p] = k;
                mirror_count++;
                r.position = p[POSITION_W-1:0];
            end
        end else begin
            r.status = STS_MISS;
            lo = 0;
            hi = mirror_count - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                c = key_order(k, mirror_keys[mid]);
                if (c == 0) begin
                    r.status    = STS_OK;
                    r.position  = mid[POSITION_W-1:0];
                    r.found_key = mirror_keys[mid];
                    break;
                end
                if (c > 0) lo = mid + 1;
                else hi = mid - 1;
            end
        end
        r.entry_total = mirror_count[TOTAL_W-1:0];
        return r;
    endfunction

    // mostly stored keys and their neighbours, so hits and equal runs are common
    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        logic [KEY_W-1:0] k;
        sel = $urandom_range(0, 9);
        k = $urandom;
        if (mirror_count > 0 && sel < 5) begin
            k = mirror_keys[$urandom_range(0, mirror_count - 1)];
        end else if (mirror_count > 0 && sel == 5) begin
            k = mirror_keys[$urandom_range(0, mirror_count - 1)];
            k = $urandom_range(0, 1) ? k + 1 : k - 1;
        end else if (sel == 6) begin
            case ($urandom_range(0, 3))
                0: k = 32'h0000_0000;
                1: k = 32'hFFFF_FFFF;
                2: k = 32'h8000_0000;
                default: k = 32'h7FFF_FFFF;
            endcase
        end
        return k;
    endfunction

    task automatic send_item(opcode_t op, logic [KEY_W-1:0] k);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= k;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        outcomes_due.push_back(table_op_outcome(op, k));
    endtask

    task automatic drain_outcomes();
        s_tvalid <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_key_signedness(logic sgn);
        drain_outcomes();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= sgn;
        @(posedge aclk);
        mirror_signed = sgn;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_empty_table();
        send_item(OP_SEARCH, 32'h0000_0000);
        send_item(OP_SEARCH, 32'hFFFF_FFFF);
        drain_outcomes();
    endtask

    task automatic test_unsigned_order();
        send_item(OP_INSERT, 32'h0000_1000);
        send_item(OP_SEARCH, 32'h0000_0010);    // below every entry
        send_item(OP_SEARCH, 32'h0000_1000);
        send_item(OP_INSERT, 32'hFFFF_FFFF);    // above the last entry
        send_item(OP_INSERT, 32'h0000_0000);    // below the first entry
        send_item(OP_INSERT, 32'h8000_0000);
        send_item(OP_INSERT, 32'h7FFF_FFFF);
        send_item(OP_INSERT, 32'h7FFF_FFFF);    // equal keys
        send_item(OP_INSERT, 32'h7FFF_FFFF);
        send_item(OP_INSERT, 32'h0000_1000);
        send_item(OP_SEARCH, 32'h7FFF_FFFF);
        send_item(OP_SEARCH, 32'h8000_0001);
        send_item(OP_SEARCH, 32'hFFFF_FFFF);
        send_item(OP_SEARCH, 32'h0000_0000);
        drain_outcomes();
    endtask

    task automatic test_signed_order();
        set_key_signedness(1'b1);
        send_item(OP_SEARCH, 32'h8000_0000);
        send_item(OP_INSERT, 32'hFFFF_FFFE);
        send_item(OP_SEARCH, 32'h0000_0000);
        send_item(OP_INSERT, 32'h8000_0000);
        send_item(OP_SEARCH, 32'hFFFF_FFFF);
        drain_outcomes();
    endtask

    // receiver holds off long enough for the block to back up into its input
    task automatic test_output_stall();
        int i;
        hold_request = 300;
        for (i = 0; i < 8; i++) send_item((i % 2) ? OP_SEARCH : OP_INSERT, pick_key());
        drain_outcomes();
    endtask

    task automatic test_random_mix(int items, int insert_pct);
        int i;
        for (i = 0; i < items; i++) begin
            send_item(($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_SEARCH,
                      pick_key());
        end
        drain_outcomes();
    endtask

    initial begin : ready_gen
        int n;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                n = hold_request;
                hold_request = 0;
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        table_outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (outcomes_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("result item with none due: %h", m_tdata);
            end else begin
                want = outcomes_due.pop_front();
                if (m_tdata[STATUS_W-1:0] !== want.status ||
                    m_tdata[POSITION_LSB +: POSITION_W] !== want.position ||
                    m_tdata[FKEY_LSB +: KEY_FIELD_W] !== want.found_key ||
                    m_tdata[TOTAL_LSB +: TOTAL_W] !== want.entry_total) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch: want status %0d pos %0d key %h total %0d",
                                 want.status, want.position, want.found_key,
                                 want.entry_total);
                        $display("          got  status %0d pos %0d key %h total %0d",
                                 m_tdata[STATUS_W-1:0], m_tdata[POSITION_LSB +: POSITION_W],
                                 m_tdata[FKEY_LSB +: KEY_FIELD_W],
                                 m_tdata[TOTAL_LSB +: TOTAL_W]);
                    end
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (5) @(posedge aclk);

        test_empty_table();
        test_unsigned_order();
        test_signed_order();
        test_output_stall();
        set_key_signedness(1'b1);
        test_random_mix(500, 35);
        set_key_signedness(1'b0);
        test_random_mix(500, 40);
        // last stretch runs without idling on either side
        idle_en = 1'b0;
        set_key_signedness(1'b1);
        test_random_mix(450, 20);

        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### sorted_key_table_core.f
design/skt_pkg.sv
design/skt_ram.sv
design/skt_dp.sv
design/skt_ctrl.sv
design/sorted_key_table_core.sv
tb/sv/sorted_key_table_core_tb.sv
